/* hw/rtl/i2w_pkg.sv */
package i2w_pkg;

  localparam int VALUE_W     = 31;
  localparam int CODE_W      = 5;
  localparam int DIGITS      = 10;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int CONV_CYCLES = VALUE_W;
  localparam int CNT_W       = $clog2(CONV_CYCLES);

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CONV_CYCLES - 1);

  localparam logic [CODE_W-1:0] WORD_ZERO      = 5'd0;
  localparam logic [CODE_W-1:0] WORD_TEN       = 5'd10;
  localparam logic [CODE_W-1:0] WORD_TENS_BASE = 5'd18;
  localparam logic [CODE_W-1:0] WORD_HUNDRED   = 5'd28;
  localparam logic [CODE_W-1:0] WORD_THOUSAND  = 5'd29;
  localparam logic [CODE_W-1:0] WORD_MILLION   = 5'd30;
  localparam logic [CODE_W-1:0] WORD_BILLION   = 5'd31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    STEP_HUND_DIGIT,
    STEP_HUND_WORD,
    STEP_TENS,
    STEP_ONES,
    STEP_SCALE
  } step_t;

  typedef struct packed {
    logic load;
    logic shift;
  } bcd_ctrl_t;

endpackage

/* hw/rtl/i2w_bcd.sv */
module i2w_bcd (
  input  logic                            clk,
  input  i2w_pkg::bcd_ctrl_t              ctrl,
  input  logic [i2w_pkg::VALUE_W-1:0]     value,
  output logic [i2w_pkg::BCD_W-1:0]       bcd
);

  logic [i2w_pkg::VALUE_W-1:0] bin;
  logic [i2w_pkg::BCD_W-1:0]   adj;

  always_comb begin
    for (int i = 0; i < i2w_pkg::DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= value;
      bcd <= '0;
    end else if (ctrl.shift) begin
      bcd <= {adj[i2w_pkg::BCD_W-2:0], bin[i2w_pkg::VALUE_W-1]};
      bin <= {bin[i2w_pkg::VALUE_W-2:0], 1'b0};
    end
  end

endmodule

/* hw/rtl/integer_to_word_tokens_top.sv */
// Words leave one per cycle at most; no new item is taken until the last word is issued.
// Binary-to-decimal shifting in the add-3 unit sets the conversion time,
// followed by a walk over four groups of five word slots and one flush state.
// The receiver cannot stall; busy stays high from acceptance until the last word is issued.
// Synchronous active-high rst returns the sequencer to idle and clears the strobe.
module integer_to_word_tokens_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [i2w_pkg::VALUE_W-1:0]      value,
  output logic                             valid,
  output logic [i2w_pkg::CODE_W-1:0]       word_code,
  output logic                             last_word
);

  i2w_pkg::state_t                state, state_next;
  i2w_pkg::step_t                 step, step_next;
  logic [1:0]                     grp, grp_next;
  logic [i2w_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic                           pend_valid, pend_valid_next;
  logic [i2w_pkg::CODE_W-1:0]     pend_code, pend_code_next;
  logic                           valid_next;
  logic [i2w_pkg::CODE_W-1:0]     word_code_next;
  logic                           last_word_next;
  i2w_pkg::bcd_ctrl_t             ctrl;
  logic [i2w_pkg::BCD_W-1:0]      bcd;
  logic [47:0]                    digits;
  logic [11:0]                    grp_bits;
  logic [3:0]                     h_dig, t_dig, o_dig;
  logic                           grp_nz;
  logic                           tok_valid;
  logic [i2w_pkg::CODE_W-1:0]     tok_code;

  i2w_bcd u_bcd (
    .clk   (clk),
    .ctrl  (ctrl),
    .value (value),
    .bcd   (bcd)
  );

  assign digits = {8'd0, bcd};
  assign busy   = (state != i2w_pkg::ST_IDLE);

  always_comb begin
    unique case (grp)
      2'd3: grp_bits = digits[47:36];
      2'd2: grp_bits = digits[35:24];
      2'd1: grp_bits = digits[23:12];
      2'd0: grp_bits = digits[11:0];
      default: grp_bits = digits[11:0];
    endcase
  end

  assign h_dig  = grp_bits[11:8];
  assign t_dig  = grp_bits[7:4];
  assign o_dig  = grp_bits[3:0];
  assign grp_nz = |grp_bits;

  always_comb begin
    tok_valid = 1'b0;
    tok_code  = i2w_pkg::WORD_ZERO;
    unique case (step)
      i2w_pkg::STEP_HUND_DIGIT: begin
        tok_valid = (h_dig != 4'd0);
        tok_code  = {1'b0, h_dig};
      end
      i2w_pkg::STEP_HUND_WORD: begin
        tok_valid = (h_dig != 4'd0);
        tok_code  = i2w_pkg::WORD_HUNDRED;
      end
      i2w_pkg::STEP_TENS: begin
        priority if (t_dig >= 4'd2) begin
          tok_valid = 1'b1;
          tok_code  = i2w_pkg::WORD_TENS_BASE + {1'b0, t_dig};
        end else if (t_dig == 4'd1) begin
          tok_valid = 1'b1;
          tok_code  = i2w_pkg::WORD_TEN + {1'b0, o_dig};
        end else begin
          tok_valid = (o_dig != 4'd0);
          tok_code  = {1'b0, o_dig};
        end
      end
      i2w_pkg::STEP_ONES: begin
        tok_valid = (t_dig >= 4'd2) && (o_dig != 4'd0);
        tok_code  = {1'b0, o_dig};
      end
      i2w_pkg::STEP_SCALE: begin
        tok_valid = grp_nz && (grp != 2'd0);
        unique case (grp)
          2'd3: tok_code = i2w_pkg::WORD_BILLION;
          2'd2: tok_code = i2w_pkg::WORD_MILLION;
          2'd1: tok_code = i2w_pkg::WORD_THOUSAND;
          2'd0: tok_code = i2w_pkg::WORD_ZERO;
          default: tok_code = i2w_pkg::WORD_ZERO;
        endcase
      end
      default: begin
        tok_valid = 1'b0;
        tok_code  = i2w_pkg::WORD_ZERO;
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    grp_next        = grp;
    cnt_next        = cnt;
    pend_valid_next = pend_valid;
    pend_code_next  = pend_code;
    valid_next      = 1'b0;
    word_code_next  = word_code;
    last_word_next  = last_word;
    ctrl            = '0;
    unique case (state)
      i2w_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          cnt_next   = '0;
          state_next = i2w_pkg::ST_CONV;
        end
      end
      i2w_pkg::ST_CONV: begin
        ctrl.shift = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == i2w_pkg::CONV_LAST) begin
          state_next      = i2w_pkg::ST_EMIT;
          grp_next        = 2'd3;
          step_next       = i2w_pkg::STEP_HUND_DIGIT;
          pend_valid_next = 1'b0;
        end
      end
      i2w_pkg::ST_EMIT: begin
        // hold each word until the next one arrives so the final one can be flagged
        if (tok_valid) begin
          if (pend_valid) begin
            valid_next     = 1'b1;
            word_code_next = pend_code;
            last_word_next = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_code_next  = tok_code;
        end
        unique case (step)
          i2w_pkg::STEP_HUND_DIGIT: step_next = i2w_pkg::STEP_HUND_WORD;
          i2w_pkg::STEP_HUND_WORD:  step_next = i2w_pkg::STEP_TENS;
          i2w_pkg::STEP_TENS:       step_next = i2w_pkg::STEP_ONES;
          i2w_pkg::STEP_ONES:       step_next = i2w_pkg::STEP_SCALE;
          i2w_pkg::STEP_SCALE: begin
            step_next = i2w_pkg::STEP_HUND_DIGIT;
            grp_next  = grp - 2'd1;
            if (grp == 2'd0) begin
              state_next = i2w_pkg::ST_FLUSH;
            end
          end
          default: step_next = i2w_pkg::STEP_HUND_DIGIT;
        endcase
      end
      i2w_pkg::ST_FLUSH: begin
        valid_next     = 1'b1;
        last_word_next = 1'b1;
        word_code_next = pend_valid ? pend_code : i2w_pkg::WORD_ZERO;
        state_next     = i2w_pkg::ST_IDLE;
      end
      default: state_next = i2w_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= i2w_pkg::ST_IDLE;
      valid      <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      valid      <= valid_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    step      <= step_next;
    grp       <= grp_next;
    cnt       <= cnt_next;
    pend_code <= pend_code_next;
    word_code <= word_code_next;
    last_word <= last_word_next;
  end

endmodule

/* hw/rtl/i2w_check.sv */
module i2w_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [i2w_pkg::VALUE_W-1:0]   value,
  input logic                          valid,
  input logic [i2w_pkg::CODE_W-1:0]    word_code,
  input logic                          last_word
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !valid)
    else $error("busy not raised after accepting an item");

  a_value_known: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> !$isunknown(value))
    else $error("unknown value on an accepted item");

  a_mid_word_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last_word |-> busy)
    else $error("non-final word issued while idle");

  a_last_word_idle: assert property (@(posedge clk) disable iff (rst)
    valid && last_word |-> !busy)
    else $error("still busy on the final word");

  a_zero_alone: assert property (@(posedge clk) disable iff (rst)
    valid && word_code == i2w_pkg::WORD_ZERO |-> last_word)
    else $error("Zero word not flagged as final");

endmodule

bind integer_to_word_tokens_top i2w_check u_i2w_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .value     (value),
  .valid     (valid),
  .word_code (word_code),
  .last_word (last_word)
);
